### hdl/ifss_pkg.sv
// Package for the interlocked flap servo sequencer: phase codes, request and command
// codes, register indexes, reset values and the state and result types.
// Depends on nothing; used by ifss_step and interlocked_flap_servo_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package ifss_pkg;

    localparam int CNT_W    = 18;
    localparam int CFG_W    = 16;
    localparam int CFG_NUM  = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int PAIR_NUM = 3;

    localparam int CLOSE_VERTICAL_MS_DEF       = 500;
    localparam int HOLD_VERTICAL_CLOSED_MS_DEF = 500;

    localparam logic [CFG_W-1:0] CFG_RESET = 16'd500;

    // Servo pair bit positions in the enable and position vectors.
    localparam int PAIR_SH = 0;
    localparam int PAIR_VE = 1;
    localparam int PAIR_HO = 2;

    typedef enum logic [2:0] {
        REG_OPEN_SHOULDER        = 3'd0,
        REG_HOLD_SHOULDER_OPEN   = 3'd1,
        REG_CLOSE_SHOULDER       = 3'd2,
        REG_HOLD_SHOULDER_CLOSED = 3'd3,
        REG_OPEN_VERTICAL        = 3'd4,
        REG_OPEN_HORIZONTAL      = 3'd5,
        REG_CLOSE_HORIZONTAL     = 3'd6,
        REG_HOLD_HORIZ_CLOSED    = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_BACK     = 2'd1,
        REQ_SHOULDER = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CMD_CLOSE = 2'd0,
        CMD_OPEN  = 2'd1
    } cmd_t;

    typedef enum logic [2:0] {
        SH_CLOSED      = 3'd0,
        SH_OPENING     = 3'd1,
        SH_HOLD_OPEN   = 3'd2,
        SH_OPENED      = 3'd3,
        SH_CLOSING     = 3'd4,
        SH_HOLD_CLOSED = 3'd5
    } sh_phase_t;

    typedef enum logic [3:0] {
        BK_CLOSED            = 4'd0,
        BK_OPEN_VERT         = 4'd1,
        BK_HOLD_VERT_OPEN    = 4'd2,
        BK_OPEN_HORIZ        = 4'd3,
        BK_HOLD_HORIZ_OPEN   = 4'd4,
        BK_OPENED            = 4'd5,
        BK_CLOSE_HORIZ       = 4'd6,
        BK_HOLD_HORIZ_CLOSED = 4'd7,
        BK_CLOSE_VERT        = 4'd8,
        BK_HOLD_VERT_CLOSED  = 4'd9
    } bk_phase_t;

    typedef logic [CFG_NUM-1:0][CFG_W-1:0] cfg_array_t;

    typedef struct packed {
        sh_phase_t             sh_phase;
        logic [CNT_W-1:0]      sh_count;
        bk_phase_t             bk_phase;
        logic [CNT_W-1:0]      bk_count;
        logic [PAIR_NUM-1:0]   enables;
        logic [PAIR_NUM-1:0]   positions;
    } seq_state_t;

    typedef struct packed {
        logic [2:0]            shoulder_phase;
        logic [3:0]            back_phase;
        logic [PAIR_NUM-1:0]   enables;
        logic [PAIR_NUM-1:0]   positions;
    } result_t;

endpackage

`default_nettype wire

### hdl/ifss_step.sv
// Next-state logic of both flap sequencers for one tick or command item.
// Depends on ifss_pkg; instantiated by interlocked_flap_servo_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ifss_step #(
    parameter int CLOSE_VERTICAL_MS       = ifss_pkg::CLOSE_VERTICAL_MS_DEF,
    parameter int HOLD_VERTICAL_CLOSED_MS = ifss_pkg::HOLD_VERTICAL_CLOSED_MS_DEF
) (
    input  wire ifss_pkg::seq_state_t cur,
    input  wire ifss_pkg::cfg_array_t cfg,
    input  wire logic [1:0]           req,
    input  wire logic [1:0]           cmd,
    output ifss_pkg::seq_state_t      nxt
);

    localparam logic [ifss_pkg::CNT_W-1:0] CV_DELAY =
        ifss_pkg::CNT_W'(CLOSE_VERTICAL_MS);
    localparam logic [ifss_pkg::CNT_W-1:0] HVC_DELAY =
        ifss_pkg::CNT_W'(HOLD_VERTICAL_CLOSED_MS);

    logic [ifss_pkg::CNT_W-1:0] sh_dec;
    logic [ifss_pkg::CNT_W-1:0] bk_dec;
    logic [ifss_pkg::CNT_W-1:0] close_sum;
    logic [ifss_pkg::CNT_W-1:0] open_sum;

    function automatic logic [ifss_pkg::CNT_W-1:0] dly(input logic [ifss_pkg::CFG_W-1:0] v);
        return ifss_pkg::CNT_W'(v);
    endfunction

    assign sh_dec    = (cur.sh_count != '0) ? cur.sh_count - 1'b1 : '0;
    assign bk_dec    = (cur.bk_count != '0) ? cur.bk_count - 1'b1 : '0;
    assign close_sum = dly(cfg[ifss_pkg::REG_CLOSE_HORIZONTAL])
                     + dly(cfg[ifss_pkg::REG_HOLD_HORIZ_CLOSED]) + CV_DELAY + HVC_DELAY;
    assign open_sum  = dly(cfg[ifss_pkg::REG_OPEN_SHOULDER])
                     + dly(cfg[ifss_pkg::REG_HOLD_SHOULDER_OPEN]);

    always_comb
    begin
        nxt = cur;
        unique case (req)
            ifss_pkg::REQ_TICK:
            begin
                nxt.sh_count = sh_dec;
                if (sh_dec == '0)
                begin
                    unique case (cur.sh_phase)
                        ifss_pkg::SH_CLOSED, ifss_pkg::SH_OPENED:
                        begin
                            nxt.enables[ifss_pkg::PAIR_SH] = 1'b0;
                        end
                        ifss_pkg::SH_OPENING:
                        begin
                            nxt.enables[ifss_pkg::PAIR_SH]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_SH] = 1'b1;
                            nxt.sh_phase = ifss_pkg::SH_HOLD_OPEN;
                            nxt.sh_count = dly(cfg[ifss_pkg::REG_OPEN_SHOULDER]);
                        end
                        ifss_pkg::SH_HOLD_OPEN:
                        begin
                            nxt.enables[ifss_pkg::PAIR_SH]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_SH] = 1'b1;
                            nxt.sh_phase = ifss_pkg::SH_OPENED;
                            nxt.sh_count = dly(cfg[ifss_pkg::REG_HOLD_SHOULDER_OPEN]);
                        end
                        ifss_pkg::SH_CLOSING:
                        begin
                            nxt.enables[ifss_pkg::PAIR_SH]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_SH] = 1'b0;
                            nxt.sh_phase = ifss_pkg::SH_HOLD_CLOSED;
                            nxt.sh_count = dly(cfg[ifss_pkg::REG_CLOSE_SHOULDER]);
                        end
                        ifss_pkg::SH_HOLD_CLOSED:
                        begin
                            nxt.enables[ifss_pkg::PAIR_SH]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_SH] = 1'b0;
                            nxt.sh_phase = ifss_pkg::SH_CLOSED;
                            nxt.sh_count = dly(cfg[ifss_pkg::REG_HOLD_SHOULDER_CLOSED]);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                nxt.bk_count = bk_dec;
                if (bk_dec == '0)
                begin
                    unique case (cur.bk_phase)
                        ifss_pkg::BK_CLOSED, ifss_pkg::BK_OPENED:
                        begin
                            nxt.enables[ifss_pkg::PAIR_VE] = 1'b0;
                            nxt.enables[ifss_pkg::PAIR_HO] = 1'b0;
                        end
                        ifss_pkg::BK_OPEN_VERT:
                        begin
                            nxt.enables[ifss_pkg::PAIR_VE]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_VE] = 1'b1;
                            nxt.bk_phase = ifss_pkg::BK_HOLD_VERT_OPEN;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_OPEN_VERTICAL]);
                        end
                        ifss_pkg::BK_HOLD_VERT_OPEN:
                        begin
                            nxt.enables[ifss_pkg::PAIR_VE]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_VE] = 1'b1;
                            nxt.bk_phase = ifss_pkg::BK_OPEN_HORIZ;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_HOLD_SHOULDER_OPEN]);
                        end
                        ifss_pkg::BK_OPEN_HORIZ:
                        begin
                            nxt.enables[ifss_pkg::PAIR_HO]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_HO] = 1'b1;
                            nxt.bk_phase = ifss_pkg::BK_HOLD_HORIZ_OPEN;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_OPEN_HORIZONTAL]);
                        end
                        ifss_pkg::BK_HOLD_HORIZ_OPEN:
                        begin
                            nxt.enables[ifss_pkg::PAIR_HO]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_HO] = 1'b1;
                            nxt.bk_phase = ifss_pkg::BK_OPENED;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_OPEN_HORIZONTAL]);
                        end
                        ifss_pkg::BK_CLOSE_HORIZ:
                        begin
                            nxt.enables[ifss_pkg::PAIR_HO]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_HO] = 1'b0;
                            nxt.bk_phase = ifss_pkg::BK_HOLD_HORIZ_CLOSED;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_CLOSE_HORIZONTAL]);
                        end
                        ifss_pkg::BK_HOLD_HORIZ_CLOSED:
                        begin
                            nxt.enables[ifss_pkg::PAIR_HO]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_HO] = 1'b0;
                            nxt.bk_phase = ifss_pkg::BK_CLOSE_VERT;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_HOLD_HORIZ_CLOSED]);
                        end
                        ifss_pkg::BK_CLOSE_VERT:
                        begin
                            nxt.enables[ifss_pkg::PAIR_VE]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_VE] = 1'b0;
                            nxt.bk_phase = ifss_pkg::BK_HOLD_VERT_CLOSED;
                            nxt.bk_count = CV_DELAY;
                        end
                        ifss_pkg::BK_HOLD_VERT_CLOSED:
                        begin
                            nxt.enables[ifss_pkg::PAIR_VE]   = 1'b1;
                            nxt.positions[ifss_pkg::PAIR_VE] = 1'b0;
                            nxt.bk_phase = ifss_pkg::BK_CLOSED;
                            nxt.bk_count = dly(cfg[ifss_pkg::REG_HOLD_SHOULDER_CLOSED]);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ifss_pkg::REQ_BACK:
            begin
                if (cmd == ifss_pkg::CMD_CLOSE)
                begin
                    nxt.bk_phase = ifss_pkg::BK_CLOSE_HORIZ;
                    nxt.bk_count = '0;
                    nxt.sh_phase = ifss_pkg::SH_CLOSING;
                    nxt.sh_count = close_sum;
                end
                else if (cmd == ifss_pkg::CMD_OPEN)
                begin
                    nxt.sh_phase = ifss_pkg::SH_OPENING;
                    nxt.sh_count = '0;
                    nxt.bk_phase = ifss_pkg::BK_OPEN_VERT;
                    nxt.bk_count = open_sum;
                end
            end
            ifss_pkg::REQ_SHOULDER:
            begin
                if (cmd == ifss_pkg::CMD_CLOSE)
                begin
                    nxt.sh_phase = ifss_pkg::SH_CLOSING;
                    if (cur.bk_phase == ifss_pkg::BK_CLOSED ||
                        cur.bk_phase == ifss_pkg::BK_HOLD_VERT_CLOSED)
                    begin
                        nxt.sh_count = '0;
                    end
                    else
                    begin
                        nxt.bk_phase = ifss_pkg::BK_CLOSE_HORIZ;
                        nxt.bk_count = '0;
                        nxt.sh_count = close_sum;
                    end
                end
                else if (cmd == ifss_pkg::CMD_OPEN)
                begin
                    nxt.sh_phase = ifss_pkg::SH_OPENING;
                    nxt.sh_count = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/interlocked_flap_servo_sequencer.sv
// Top level of the interlocked flap servo sequencer: configuration registers,
// sequencer state, result register with skid stage, and the APB-style port.
// Depends on ifss_pkg and ifss_step.
`timescale 1ns / 1ps
`default_nettype none

// Each item (a one millisecond tick or a flap command) is applied to the sequencer
// state in the cycle it is accepted; its result goes to the output register, or to the
// skid stage while a result is stalled, so the block takes one item per clock while
// in_stall is low. The skid stage behind the output register holds one more item;
// in_stall rises only when both are full. Delay registers should be written while no
// item is in flight; reads return the stored 16-bit value in the low half of prdata.
module interlocked_flap_servo_sequencer #(
    parameter int CLOSE_VERTICAL_MS       = ifss_pkg::CLOSE_VERTICAL_MS_DEF,
    parameter int HOLD_VERTICAL_CLOSED_MS = ifss_pkg::HOLD_VERTICAL_CLOSED_MS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  req_type,
    input  wire logic [1:0]                  command,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [2:0]                       shoulder_phase,
    output logic [3:0]                       back_phase,
    output logic                             shoulder_driven,
    output logic                             shoulder_at_open,
    output logic                             vertical_driven,
    output logic                             vertical_at_open,
    output logic                             horizontal_driven,
    output logic                             horizontal_at_open,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ifss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ifss_pkg::DATA_W-1:0] pwdata,
    output logic [ifss_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    localparam logic [ifss_pkg::CNT_W-1:0] RESET_CLOSE_SUM =
        ifss_pkg::CNT_W'(2 * int'(ifss_pkg::CFG_RESET) + CLOSE_VERTICAL_MS
                         + HOLD_VERTICAL_CLOSED_MS);

    ifss_pkg::cfg_array_t cfg_reg;
    ifss_pkg::seq_state_t state_reg;
    ifss_pkg::seq_state_t state_next;
    ifss_pkg::result_t    res_next;
    ifss_pkg::result_t    out_reg;
    ifss_pkg::result_t    skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_fire;
    logic                 slot_free;
    logic                 cfg_write;
    logic [2:0]           cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[4:2];
    assign prdata    = ifss_pkg::DATA_W'(cfg_reg[cfg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= {ifss_pkg::CFG_NUM{ifss_pkg::CFG_RESET}};
        end
        else if (cfg_write)
        begin
            cfg_reg[cfg_idx] <= pwdata[ifss_pkg::CFG_W-1:0];
        end
    end

    ifss_step #(
        .CLOSE_VERTICAL_MS       (CLOSE_VERTICAL_MS),
        .HOLD_VERTICAL_CLOSED_MS (HOLD_VERTICAL_CLOSED_MS)
    ) u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (req_type),
        .cmd (command),
        .nxt (state_next)
    );

    assign res_next.shoulder_phase = state_next.sh_phase;
    assign res_next.back_phase     = state_next.bk_phase;
    assign res_next.enables        = state_next.enables;
    assign res_next.positions      = state_next.positions;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid & ~skid_valid_reg;
    assign slot_free = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.sh_phase  <= ifss_pkg::SH_CLOSING;
            state_reg.sh_count  <= RESET_CLOSE_SUM;
            state_reg.bk_phase  <= ifss_pkg::BK_CLOSE_HORIZ;
            state_reg.bk_count  <= '0;
            state_reg.enables   <= '1;
            state_reg.positions <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign shoulder_phase     = out_reg.shoulder_phase;
    assign back_phase         = out_reg.back_phase;
    assign shoulder_driven    = out_reg.enables[ifss_pkg::PAIR_SH];
    assign shoulder_at_open   = out_reg.positions[ifss_pkg::PAIR_SH];
    assign vertical_driven    = out_reg.enables[ifss_pkg::PAIR_VE];
    assign vertical_at_open   = out_reg.positions[ifss_pkg::PAIR_VE];
    assign horizontal_driven  = out_reg.enables[ifss_pkg::PAIR_HO];
    assign horizontal_at_open = out_reg.positions[ifss_pkg::PAIR_HO];

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid stage holds an item while the output register is empty.");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("Accepted item did not produce a pending result.");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_valid_reg) |=> (out_reg == $past(res_next)))
        else $error("Result register does not hold the state after the item.");

    a_state_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(state_reg))
        else $error("Sequencer state changed without an accepted item.");

endmodule

`default_nettype wire

### tb/interlocked_flap_servo_sequencer_test.sv
// Self-checking testbench for interlocked_flap_servo_sequencer: flap commands and ticks
// go in as items, and every result is checked against a shadow copy of both sequencers.
// Depends on ifss_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module interlocked_flap_servo_sequencer_test;

    import ifss_pkg::*;

    localparam int unsigned RUN_LIMIT_NS = 3_000_000;
    localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;
    localparam int          RANDOM_ITEMS = 365;

    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam logic [1:0] CMD_SPARE_LO = 2'd2;
    localparam logic [1:0] CMD_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [1:0] cmd;
    } flap_item_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [1:0]          req_type  = '0;
    logic [1:0]          command   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          shoulder_phase;
    logic [3:0]          back_phase;
    logic                shoulder_driven;
    logic                shoulder_at_open;
    logic                vertical_driven;
    logic                vertical_at_open;
    logic                horizontal_driven;
    logic                horizontal_at_open;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    interlocked_flap_servo_sequencer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .req_type           (req_type),
        .command            (command),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .shoulder_phase     (shoulder_phase),
        .back_phase         (back_phase),
        .shoulder_driven    (shoulder_driven),
        .shoulder_at_open   (shoulder_at_open),
        .vertical_driven    (vertical_driven),
        .vertical_at_open   (vertical_at_open),
        .horizontal_driven  (horizontal_driven),
        .horizontal_at_open (horizontal_at_open),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    logic [CFG_W-1:0]    delay_ms [CFG_NUM];
    sh_phase_t           sh_phase_now;
    logic [CNT_W-1:0]    sh_wait;
    bk_phase_t           bk_phase_now;
    logic [CNT_W-1:0]    bk_wait;
    logic [PAIR_NUM-1:0] pair_on;
    logic [PAIR_NUM-1:0] pair_open;

    flap_item_t          flap_requests [$];
    result_t             servo_results_due [$];
    flap_item_t          next_req;
    result_t             due_now;

    int                  mismatches   = 0;
    int                  results_seen = 0;
    int                  random_left  = 0;
    int                  gap_left     = 0;
    int                  send_calm    = 0;
    int                  stall_left   = 0;
    int                  recv_calm    = 0;
    int                  hold_cycles  = 0;
    bit                  hold_done    = 1'b0;
    bit                  item_taken   = 1'b0;
    int                  setting;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CNT_W-1:0] clip_count(int unsigned v);
        return (v > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : v[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] closing_total();
        int unsigned sum;
        sum = int'(delay_ms[REG_CLOSE_HORIZONTAL]) + int'(delay_ms[REG_HOLD_HORIZ_CLOSED])
            + CLOSE_VERTICAL_MS_DEF + HOLD_VERTICAL_CLOSED_MS_DEF;
        return clip_count(sum);
    endfunction

    task automatic drive_pair(int pair, bit open);
        pair_on[pair]   = 1'b1;
        pair_open[pair] = open;
    endtask

    task automatic shoulder_to(sh_phase_t ph, int unsigned d);
        sh_phase_now = ph;
        sh_wait      = clip_count(d);
    endtask

    task automatic back_to(bk_phase_t ph, int unsigned d);
        bk_phase_now = ph;
        bk_wait      = clip_count(d);
    endtask

    task automatic reset_model();
        int i;
        for (i = 0; i < CFG_NUM; i++)
            delay_ms[i] = CFG_RESET;
        pair_on   = '1;
        pair_open = '0;
        back_to(BK_CLOSE_HORIZ, 0);
        shoulder_to(SH_CLOSING, closing_total());
    endtask

    task automatic shoulder_step();
        case (sh_phase_now)
            SH_CLOSED:      pair_on[PAIR_SH] = 1'b0;
            SH_OPENING:
            begin
                drive_pair(PAIR_SH, 1'b1);
                shoulder_to(SH_HOLD_OPEN, delay_ms[REG_OPEN_SHOULDER]);
            end
            SH_HOLD_OPEN:
            begin
                drive_pair(PAIR_SH, 1'b1);
                shoulder_to(SH_OPENED, delay_ms[REG_HOLD_SHOULDER_OPEN]);
            end
            SH_OPENED:      pair_on[PAIR_SH] = 1'b0;
            SH_CLOSING:
            begin
                drive_pair(PAIR_SH, 1'b0);
                shoulder_to(SH_HOLD_CLOSED, delay_ms[REG_CLOSE_SHOULDER]);
            end
            SH_HOLD_CLOSED:
            begin
                drive_pair(PAIR_SH, 1'b0);
                shoulder_to(SH_CLOSED, delay_ms[REG_HOLD_SHOULDER_CLOSED]);
            end
            default: ;
        endcase
    endtask

    task automatic back_step();
        case (bk_phase_now)
            BK_CLOSED, BK_OPENED:
            begin
                pair_on[PAIR_VE] = 1'b0;
                pair_on[PAIR_HO] = 1'b0;
            end
            BK_OPEN_VERT:
            begin
                drive_pair(PAIR_VE, 1'b1);
                back_to(BK_HOLD_VERT_OPEN, delay_ms[REG_OPEN_VERTICAL]);
            end
            BK_HOLD_VERT_OPEN:
            begin
                drive_pair(PAIR_VE, 1'b1);
                back_to(BK_OPEN_HORIZ, delay_ms[REG_HOLD_SHOULDER_OPEN]);
            end
            BK_OPEN_HORIZ:
            begin
                drive_pair(PAIR_HO, 1'b1);
                back_to(BK_HOLD_HORIZ_OPEN, delay_ms[REG_OPEN_HORIZONTAL]);
            end
            BK_HOLD_HORIZ_OPEN:
            begin
                drive_pair(PAIR_HO, 1'b1);
                back_to(BK_OPENED, delay_ms[REG_OPEN_HORIZONTAL]);
            end
            BK_CLOSE_HORIZ:
            begin
                drive_pair(PAIR_HO, 1'b0);
                back_to(BK_HOLD_HORIZ_CLOSED, delay_ms[REG_CLOSE_HORIZONTAL]);
            end
            BK_HOLD_HORIZ_CLOSED:
            begin
                drive_pair(PAIR_HO, 1'b0);
                back_to(BK_CLOSE_VERT, delay_ms[REG_HOLD_HORIZ_CLOSED]);
            end
            BK_CLOSE_VERT:
            begin
                drive_pair(PAIR_VE, 1'b0);
                back_to(BK_HOLD_VERT_CLOSED, CLOSE_VERTICAL_MS_DEF);
            end
            BK_HOLD_VERT_CLOSED:
            begin
                drive_pair(PAIR_VE, 1'b0);
                back_to(BK_CLOSED, delay_ms[REG_HOLD_SHOULDER_CLOSED]);
            end
            default: ;
        endcase
    endtask

    task automatic advance_sequencers(logic [1:0] rq, logic [1:0] cm);
        result_t due;
        int unsigned open_wait;
        case (rq)
            REQ_TICK:
            begin
                if (sh_wait != 0)
                    sh_wait--;
                if (sh_wait == 0)
                    shoulder_step();
                if (bk_wait != 0)
                    bk_wait--;
                if (bk_wait == 0)
                    back_step();
            end
            REQ_BACK:
            begin
                if (cm == CMD_CLOSE) begin
                    back_to(BK_CLOSE_HORIZ, 0);
                    shoulder_to(SH_CLOSING, closing_total());
                end else if (cm == CMD_OPEN) begin
                    open_wait = int'(delay_ms[REG_OPEN_SHOULDER])
                              + int'(delay_ms[REG_HOLD_SHOULDER_OPEN]);
                    shoulder_to(SH_OPENING, 0);
                    back_to(BK_OPEN_VERT, open_wait);
                end
            end
            REQ_SHOULDER:
            begin
                if (cm == CMD_CLOSE) begin
                    if (bk_phase_now == BK_CLOSED || bk_phase_now == BK_HOLD_VERT_CLOSED) begin
                        shoulder_to(SH_CLOSING, 0);
                    end else begin
                        back_to(BK_CLOSE_HORIZ, 0);
                        shoulder_to(SH_CLOSING, closing_total());
                    end
                end else if (cm == CMD_OPEN) begin
                    shoulder_to(SH_OPENING, 0);
                end
            end
            default: ;
        endcase
        due.shoulder_phase = sh_phase_now;
        due.back_phase     = bk_phase_now;
        due.enables        = pair_on;
        due.positions      = pair_open;
        servo_results_due.push_back(due);
    endtask

    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(199);
        if (r < 3) begin
            calm = $urandom_range(60, 20);
            return 0;
        end
        if (r < 110)
            return 0;
        if (r < 170)
            return $urandom_range(3, 1);
        if (r < 192)
            return $urandom_range(10, 4);
        return $urandom_range(40, 15);
    endfunction

    task automatic add_item(logic [1:0] rq, logic [1:0] cm);
        flap_item_t it;
        it.req = rq;
        it.cmd = cm;
        flap_requests.push_back(it);
        if (rq != REQ_RESERVED && (rq == REQ_TICK || cm == CMD_CLOSE || cm == CMD_OPEN))
            random_left--;
    endtask

    // A command followed by a burst of ticks; long bursts let the vertical close finish.
    task automatic queue_episode();
        int r;
        int ticks;
        r = $urandom_range(99);
        if (r < 6)
            add_item(REQ_RESERVED, 2'($urandom_range(3)));
        else if (r < 12)
            add_item(2'($urandom_range(REQ_SHOULDER, REQ_BACK)),
                     2'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)));
        else if (r < 36)
            add_item(REQ_BACK, CMD_OPEN);
        else if (r < 54)
            add_item(REQ_BACK, CMD_CLOSE);
        else if (r < 74)
            add_item(REQ_SHOULDER, CMD_OPEN);
        else
            add_item(REQ_SHOULDER, CMD_CLOSE);
        r = $urandom_range(99);
        if (r < 70)
            ticks = $urandom_range(12, 1);
        else if (r < 92)
            ticks = $urandom_range(60, 13);
        else
            ticks = $urandom_range(560, 480);
        if (ticks > random_left)
            ticks = (random_left > 0) ? random_left : 0;
        repeat (ticks) add_item(REQ_TICK, 2'($urandom_range(3)));
    endtask

    task automatic write_delay(reg_index_t idx, logic [15:0] value, logic [15:0] upper);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        delay_ms[idx] = value;
    endtask

    task automatic load_settings(int which);
        int i;
        int r;
        logic [15:0] v;
        logic [15:0] hi;
        for (i = 0; i < CFG_NUM; i++) begin
            hi = '0;
            r  = $urandom_range(3);
            case (which)
                1:       v = '0;
                2:       v = 16'($urandom_range(3));
                3:
                begin
                    v  = 16'($urandom_range(25));
                    hi = 16'($urandom());
                end
                default:
                begin
                    v  = (i == CFG_NUM - 1) ? 16'hFFFF :
                         (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'd60000 : 16'hFFFF;
                    hi = 16'($urandom());
                end
            endcase
            write_delay(reg_index_t'(i), v, hi);
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (flap_requests.size() != 0 || in_valid || servo_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || item_taken) begin
            item_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (flap_requests.size() != 0) begin
                next_req = flap_requests.pop_front();
                in_valid <= 1'b1;
                req_type <= next_req.req;
                command  <= next_req.cmd;
                gap_left = pick_pause(send_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            advance_sequencers(req_type, command);
            item_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (results_seen >= 200 && !hold_done) begin
            out_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles >= 80)
                hold_done = 1'b1;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            stall_left = pick_pause(recv_calm);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (servo_results_due.size() == 0) begin
                $error("result arrived with no item outstanding");
                mismatches++;
            end else begin
                due_now = servo_results_due.pop_front();
                check_field("shoulder_phase", due_now.shoulder_phase, shoulder_phase);
                check_field("back_phase", due_now.back_phase, back_phase);
                check_field("shoulder_driven", due_now.enables[PAIR_SH], shoulder_driven);
                check_field("shoulder_at_open", due_now.positions[PAIR_SH], shoulder_at_open);
                check_field("vertical_driven", due_now.enables[PAIR_VE], vertical_driven);
                check_field("vertical_at_open", due_now.positions[PAIR_VE], vertical_at_open);
                check_field("horizontal_driven", due_now.enables[PAIR_HO], horizontal_driven);
                check_field("horizontal_at_open", due_now.positions[PAIR_HO],
                            horizontal_at_open);
            end
        end
    end

    initial begin
        reset_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_item(REQ_TICK, CMD_SPARE_HI);
        add_item(REQ_RESERVED, CMD_OPEN);
        add_item(REQ_BACK, CMD_SPARE_LO);
        add_item(REQ_SHOULDER, CMD_SPARE_HI);
        add_item(REQ_TICK, CMD_CLOSE);
        wait_drained();

        for (setting = 1; setting <= 4; setting++) begin
            load_settings(setting);
            if (setting == 1) begin
                // With zero delays the open sequence runs one phase per tick; a shoulder
                // close with the back open shuts it, then one while it holds closed.
                add_item(REQ_BACK, CMD_OPEN);
                repeat (6) add_item(REQ_TICK, CMD_OPEN);
                add_item(REQ_SHOULDER, CMD_CLOSE);
                repeat (3) add_item(REQ_TICK, CMD_CLOSE);
                add_item(REQ_SHOULDER, CMD_CLOSE);
                repeat (2) add_item(REQ_TICK, CMD_SPARE_LO);
                add_item(REQ_SHOULDER, CMD_OPEN);
                add_item(REQ_BACK, CMD_CLOSE);
                add_item(REQ_TICK, CMD_SPARE_HI);
            end
            random_left = RANDOM_ITEMS;
            while (random_left > 0)
                queue_episode();
            wait_drained();
        end

        if (mismatches == 0 && servo_results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
